@@ src/binary_trie_prefix_match_macros.svh @@
// Assertion macros for the trie prefix matcher RTL.
`ifndef BINARY_TRIE_PREFIX_MATCH_MACROS_SVH
`define BINARY_TRIE_PREFIX_MATCH_MACROS_SVH

`ifndef SYNTHESIS
`define BTPM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("btpm: property violated");
`define BTPM_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("btpm: invariant violated");
`else
`define BTPM_ASSERT(label, clk, rst_n, prop)
`define BTPM_ASSERT_ALWAYS(label, clk, rst_n, expr)
`endif

`endif

@@ src/btpm_pkg.sv @@
// Package with the constants, codes and types of the trie prefix matcher.
package btpm_pkg;

    localparam int ADDR_BITS   = 32;
    localparam int NODE_COUNT  = 4096;
    localparam int OWNER_COUNT = 64;

    localparam int MASK_W  = 64;
    localparam int PLEN_W  = 6;
    localparam int OWNER_W = 6;
    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int COUNT_W = $clog2(NODE_COUNT + 1);
    localparam int LEVEL_W = $clog2(ADDR_BITS + 1);

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_LOOKUP = 1'b1
    } t_kind;

    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FULL = 1'b1
    } t_status;

    typedef struct packed {
        logic [NODE_W-1:0] link1;
        logic [NODE_W-1:0] link0;
        logic [MASK_W-1:0] mask;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [NODE_W-1:0] raddr;
    } t_ram_req;

endpackage

@@ src/btpm_ifs.sv @@
// Request and response channel interfaces of the trie prefix matcher.
interface btpm_req_if;
    import btpm_pkg::*;

    logic                 valid;
    logic                 ready;
    t_kind                kind;
    logic [ADDR_BITS-1:0] address;
    logic [PLEN_W-1:0]    prefix_len;
    logic [OWNER_W-1:0]   owner;

    modport source (output valid, kind, address, prefix_len, owner, input ready);
    modport sink   (input valid, kind, address, prefix_len, owner, output ready);
endinterface

interface btpm_rsp_if;
    import btpm_pkg::*;

    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] owner_mask;
    t_status           status;

    modport source (output valid, owner_mask, status, input ready);
    modport sink   (input valid, owner_mask, status, output ready);
endinterface

@@ src/btpm_node_ram.sv @@
// Node store: one entry per non-root trie node, registered read.
module btpm_node_ram (
    input  logic              i_clk,
    input  btpm_pkg::t_ram_req i_req,
    output btpm_pkg::t_entry  o_rdata
);
    import btpm_pkg::*;

    t_entry r_mem [NODE_COUNT];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/btpm_walker.sv @@
// Trie walk controller with root node, node allocator and response register.
`include "binary_trie_prefix_match_macros.svh"

module btpm_walker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    btpm_req_if.sink            i_req,
    btpm_rsp_if.source          o_rsp,
    output btpm_pkg::t_ram_req  o_ram_req,
    input  btpm_pkg::t_entry    i_ram_rdata
);
    import btpm_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state               r_state, n_state;
    t_kind                r_kind, n_kind;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [LEVEL_W-1:0]   r_plen, n_plen;
    logic [OWNER_W-1:0]   r_owner, n_owner;
    logic [NODE_W-1:0]    r_node, n_node;
    logic                 r_fresh, n_fresh;
    logic [LEVEL_W-1:0]   r_level, n_level;
    logic [MASK_W-1:0]    r_acc, n_acc;
    logic [COUNT_W-1:0]   r_count, n_count;
    t_entry               r_root, n_root;
    logic                 r_out_valid, n_out_valid;
    logic [MASK_W-1:0]    r_out_mask, n_out_mask;
    t_status              r_out_status, n_out_status;

    t_entry            cur;
    t_entry            wr_data;
    t_ram_req          ram_req;
    logic              do_write;
    logic              bit_now;
    logic [NODE_W-1:0] child;
    logic [MASK_W-1:0] acc_next;
    logic [MASK_W-1:0] owner_bit;
    logic              out_free;
    logic              lookup_last;

    always_comb begin
        if (r_node == '0) begin
            cur = r_root;
        end else if (r_fresh) begin
            cur = '0;
        end else begin
            cur = i_ram_rdata;
        end
    end

    assign bit_now     = r_addr[ADDR_BITS-1];
    assign child       = bit_now ? cur.link1 : cur.link0;
    assign acc_next    = r_acc | cur.mask;
    assign owner_bit   = (int'(r_owner) < OWNER_COUNT) ? (MASK_W'(1) << r_owner) : '0;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign lookup_last = (r_level == LEVEL_W'(ADDR_BITS)) || (child == '0);

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_addr       = r_addr;
        n_plen       = r_plen;
        n_owner      = r_owner;
        n_node       = r_node;
        n_fresh      = r_fresh;
        n_level      = r_level;
        n_acc        = r_acc;
        n_count      = r_count;
        n_root       = r_root;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_mask   = r_out_mask;
        n_out_status = r_out_status;
        ram_req      = '0;
        do_write     = 1'b0;
        wr_data      = cur;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_WALK;
                    n_kind  = i_req.kind;
                    n_addr  = i_req.address;
                    n_plen  = (int'(i_req.prefix_len) > ADDR_BITS) ?
                              LEVEL_W'(ADDR_BITS) : LEVEL_W'(i_req.prefix_len);
                    n_owner = i_req.owner;
                    n_node  = '0;
                    n_fresh = 1'b0;
                    n_level = '0;
                    n_acc   = '0;
                end
            end
            ST_WALK: begin
                if (r_kind == KIND_LOOKUP) begin
                    if (lookup_last) begin
                        if (out_free) begin
                            n_out_valid  = 1'b1;
                            n_out_mask   = acc_next;
                            n_out_status = STATUS_OK;
                            n_state      = ST_IDLE;
                        end
                    end else begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = child;
                        n_node        = child;
                        n_fresh       = 1'b0;
                        n_level       = r_level + LEVEL_W'(1);
                        n_addr        = r_addr << 1;
                        n_acc         = acc_next;
                    end
                end else begin
                    if (r_level == r_plen) begin
                        if (out_free) begin
                            do_write       = 1'b1;
                            wr_data.mask   = cur.mask | owner_bit;
                            n_out_valid    = 1'b1;
                            n_out_mask     = '0;
                            n_out_status   = STATUS_OK;
                            n_state        = ST_IDLE;
                        end
                    end else if (child != '0) begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = child;
                        n_node        = child;
                        n_fresh       = 1'b0;
                        n_level       = r_level + LEVEL_W'(1);
                        n_addr        = r_addr << 1;
                    end else if (r_count == COUNT_W'(NODE_COUNT)) begin
                        if (out_free) begin
                            do_write     = 1'b1;
                            n_out_valid  = 1'b1;
                            n_out_mask   = '0;
                            n_out_status = STATUS_FULL;
                            n_state      = ST_IDLE;
                        end
                    end else begin
                        do_write = 1'b1;
                        if (bit_now) begin
                            wr_data.link1 = r_count[NODE_W-1:0];
                        end else begin
                            wr_data.link0 = r_count[NODE_W-1:0];
                        end
                        n_node  = r_count[NODE_W-1:0];
                        n_fresh = 1'b1;
                        n_count = r_count + COUNT_W'(1);
                        n_level = r_level + LEVEL_W'(1);
                        n_addr  = r_addr << 1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (do_write) begin
            if (r_node == '0) begin
                n_root = wr_data;
            end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_node;
                ram_req.wdata = wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= COUNT_W'(1);
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_root       <= n_root;
            r_out_valid  <= n_out_valid;
            r_kind       <= n_kind;
            r_addr       <= n_addr;
            r_plen       <= n_plen;
            r_owner      <= n_owner;
            r_node       <= n_node;
            r_fresh      <= n_fresh;
            r_level      <= n_level;
            r_acc        <= n_acc;
            r_out_mask   <= n_out_mask;
            r_out_status <= n_out_status;
        end
    end

    assign i_req.ready      = (r_state == ST_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.owner_mask = r_out_mask;
    assign o_rsp.status     = r_out_status;
    assign o_ram_req        = ram_req;

    `BTPM_ASSERT(a_no_rw_clash, i_clk, i_rst_n, (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    `BTPM_ASSERT(a_read_consumed, i_clk, i_rst_n, ram_req.re |=> (r_state == ST_WALK && !r_fresh && r_node != '0))
    `BTPM_ASSERT(a_level_bound, i_clk, i_rst_n, (r_state == ST_WALK) |-> (r_level <= LEVEL_W'(ADDR_BITS)))
    `BTPM_ASSERT(a_insert_depth, i_clk, i_rst_n, (r_state == ST_WALK && r_kind == KIND_INSERT) |-> (r_level <= r_plen))
    `BTPM_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, (r_count != '0) && (r_count <= COUNT_W'(NODE_COUNT)))
endmodule

@@ src/binary_trie_prefix_match.sv @@
// Binary trie prefix matcher: inserts owner-tagged prefixes and looks up
// 32-bit addresses, returning the owner mask of every matching prefix.
// Each item walks the trie one level per cycle, one read of the node RAM per
// level. The root sits in flip-flops and every other node is zeroed as it is
// allocated, so there is no clearing pass after reset. An insert that needs a
// node while all 4096 are in use returns status full and marks no owner. A
// finished result waits in an output register while the next transfer is
// taken in.
module binary_trie_prefix_match (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btpm_req_if.sink   i_req,
    btpm_rsp_if.source o_rsp
);
    import btpm_pkg::*;

    t_ram_req ram_req;
    t_entry   ram_rdata;

    btpm_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    btpm_node_ram u_node_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );
endmodule
